// ===== design/assert_macros.svh =====
// Assertion macros shared by the heap unit.
// Depends on nothing; included inside module bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another at the same edge.
`define ASSERT_IMP(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");

// Check that a condition implies another at the next edge.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");

`endif

// ===== design/imh_pkg.sv =====
// Package for the indexed min-heap unit: sizes, operation and status codes, states.
// Depends on nothing.
package imh_pkg;
	localparam int CAPACITY_DEF = 256;
	localparam int KEY_BITS_DEF = 32;
	localparam int ITEM_BITS = 8;
	localparam int ITEM_COUNT = 256;
	localparam int KEY_W = 32;
	localparam int OCC_W = 9;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_EXTRACT = 2'd1,
		OP_DECREASE = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_EMPTY = 3'd1,
		ST_IGNORED = 3'd2,
		ST_FULL = 3'd3,
		ST_DUP = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_INS_CHK,
		S_DEC_CHK,
		S_DEC_CMP,
		S_EXT_RD,
		S_EXT_LAST,
		S_UP_RD,
		S_UP_CMP,
		S_DN_RD,
		S_DN_CMP,
		S_DN_SWAP,
		S_PLACE,
		S_DONE
	} state_t;
endpackage

// ===== design/indexed_min_heap_decrease_key_unit.sv =====
// Indexed binary min-heap with decrease-key, top level.
// Depends on imh_pkg and assert_macros.svh.
// One operation at a time: in_ready stays low from the input transfer until the result
// has been transferred. After reset all ITEM_COUNT (256) entries of the position table
// are cleared with in_ready low. Keys and items sit in one synchronous memory, item
// positions in another, both with registered read data. Insert and decrease-key sift up
// with a parent read and a compare-and-move per level; extract sifts down with a left
// read, a right read and a compare and move per level. A full insert, an empty extract
// or a no-op goes from the input transfer straight to the result state.
module indexed_min_heap_decrease_key_unit #(
	parameter int CAPACITY = imh_pkg::CAPACITY_DEF,
	parameter int KEY_BITS = imh_pkg::KEY_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [1:0] mode,
	input  logic [imh_pkg::ITEM_BITS-1:0] item_id,
	input  logic [imh_pkg::KEY_W-1:0] key_value,
	output logic out_valid,
	input  logic out_ready,
	output logic [2:0] status,
	output logic [imh_pkg::ITEM_BITS-1:0] out_item,
	output logic [imh_pkg::KEY_W-1:0] out_key,
	output logic [imh_pkg::OCC_W-1:0] occupancy
);
	import imh_pkg::*;
	`include "assert_macros.svh"

	localparam int SW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int KB = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
	localparam logic [KB-1:0] KEY_INF = {KB{1'b1}};
	localparam logic [SW:0] POS_ABSENT = {1'b1, {SW{1'b0}}};

	logic [KB-1:0] key_mem [CAPACITY];
	logic [ITEM_BITS-1:0] itm_mem [CAPACITY];
	logic [SW:0] pos_mem [ITEM_COUNT];

	state_t state_q, state_d;
	logic [CW-1:0] cnt_q;
	logic [SW-1:0] s_q;
	logic [KB-1:0] k_q;
	logic [ITEM_BITS-1:0] it_q;
	logic [KB-1:0] rk_q;
	logic [ITEM_BITS-1:0] ri_q;
	logic [KB-1:0] lk_q;
	logic [ITEM_BITS-1:0] li_q;
	logic [SW:0] pos_rd_q;
	logic [ITEM_BITS-1:0] clr_q;

	status_t status_q;
	logic [ITEM_BITS-1:0] oitem_q;
	logic [KB-1:0] okey_q;
	logic ovalid_q;

	logic hk_we, pos_we;
	logic [SW-1:0] hk_ra;
	logic [KB-1:0] hk_wk;
	logic [ITEM_BITS-1:0] hk_wi;
	logic [ITEM_BITS-1:0] pos_wa, pos_ra;
	logic [SW:0] pos_wd;

	logic take, full;
	logic [SW-1:0] parent, lch, rch;
	logic [SW:0] lch_w, rch_w;
	logic rgt_ok, pick_r;
	logic [KB-1:0] pick_k;
	logic [ITEM_BITS-1:0] pick_i;
	logic [SW-1:0] pick_s;

	assign take = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE) && !ovalid_q;
	assign full = cnt_q >= CW'(CAPACITY);
	assign parent = SW'((s_q - 1'b1) >> 1);
	assign lch_w = {s_q, 1'b1};
	assign rch_w = (SW + 1)'({s_q, 1'b1}) + 1'b1;
	assign lch = lch_w[SW-1:0];
	assign rch = rch_w[SW-1:0];
	assign rgt_ok = rch_w < (SW + 1)'(cnt_q);
	assign pick_r = rgt_ok && (rk_q < lk_q);
	assign pick_k = pick_r ? rk_q : lk_q;
	assign pick_i = pick_r ? ri_q : li_q;
	assign pick_s = pick_r ? rch : lch;

	always_ff @(posedge clk) begin
		if (hk_we) begin
			key_mem[s_q] <= hk_wk;
			itm_mem[s_q] <= hk_wi;
		end
		rk_q <= key_mem[hk_ra];
		ri_q <= itm_mem[hk_ra];
		if (pos_we) begin
			pos_mem[pos_wa] <= pos_wd;
		end
		pos_rd_q <= pos_mem[pos_ra];
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_q == ITEM_BITS'(ITEM_COUNT - 1)) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (take) begin
					unique case (op_t'(mode))
						OP_INSERT: state_d = full ? S_DONE : S_INS_CHK;
						OP_EXTRACT: state_d = (cnt_q == '0) ? S_DONE : S_EXT_RD;
						OP_DECREASE: state_d = S_DEC_CHK;
						OP_NONE: state_d = S_DONE;
					endcase
				end
			end
			S_INS_CHK: state_d = pos_rd_q[SW] ? S_UP_RD : S_DONE;
			S_DEC_CHK: state_d = pos_rd_q[SW] ? S_DONE : S_DEC_CMP;
			S_DEC_CMP: state_d = (k_q < rk_q) ? S_UP_RD : S_DONE;
			S_EXT_RD: state_d = S_EXT_LAST;
			S_EXT_LAST: state_d = (cnt_q == '0) ? S_DONE : S_DN_RD;
			S_UP_RD: state_d = (s_q == '0) ? S_PLACE : S_UP_CMP;
			S_UP_CMP: state_d = (k_q < rk_q) ? S_UP_RD : S_PLACE;
			S_DN_RD: state_d = (lch_w < (SW + 1)'(cnt_q)) ? S_DN_CMP : S_PLACE;
			S_DN_CMP: state_d = S_DN_SWAP;
			S_DN_SWAP: state_d = (pick_k < k_q) ? S_DN_RD : S_PLACE;
			S_PLACE: state_d = S_IDLE;
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// k_q/it_q hold the moving entry; s_q is the hole it travels through
	always_comb begin
		hk_we = 1'b0;
		hk_wk = k_q;
		hk_wi = it_q;
		hk_ra = s_q;
		pos_we = 1'b0;
		pos_wa = it_q;
		pos_wd = {1'b0, s_q};
		pos_ra = item_id;
		unique case (state_q)
			S_CLEAR: begin
				pos_we = 1'b1;
				pos_wa = clr_q;
				pos_wd = POS_ABSENT;
			end
			S_IDLE: hk_ra = '0;
			S_DEC_CHK: hk_ra = pos_rd_q[SW-1:0];
			S_EXT_RD: begin
				hk_ra = SW'(cnt_q - 1'b1);
				pos_we = 1'b1;
				pos_wa = ri_q;
				pos_wd = POS_ABSENT;
			end
			S_UP_RD: hk_ra = parent;
			S_UP_CMP: begin
				if (k_q < rk_q) begin
					hk_we = 1'b1;
					hk_wk = rk_q;
					hk_wi = ri_q;
					pos_we = 1'b1;
					pos_wa = ri_q;
				end
			end
			S_DN_RD: hk_ra = lch;
			S_DN_CMP: hk_ra = rch;
			S_DN_SWAP: begin
				if (pick_k < k_q) begin
					hk_we = 1'b1;
					hk_wk = pick_k;
					hk_wi = pick_i;
					pos_we = 1'b1;
					pos_wa = pick_i;
				end
			end
			S_PLACE: begin
				hk_we = 1'b1;
				pos_we = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			cnt_q <= '0;
			clr_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
			if (state_q == S_PLACE || state_q == S_DONE) ovalid_q <= 1'b1;
			else if (out_ready) ovalid_q <= 1'b0;
			if (state_q == S_INS_CHK && pos_rd_q[SW]) cnt_q <= cnt_q + 1'b1;
			else if (state_q == S_EXT_RD) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (take) begin
					it_q <= item_id;
					k_q <= KB'(key_value);
					oitem_q <= '0;
					okey_q <= '0;
					status_q <= ST_OK;
					unique case (op_t'(mode))
						OP_INSERT: if (full) status_q <= ST_FULL;
						OP_EXTRACT: if (cnt_q == '0) begin
							status_q <= ST_EMPTY;
							okey_q <= KEY_INF;
						end
						OP_DECREASE: ;
						OP_NONE: ;
					endcase
				end
			end
			S_INS_CHK: begin
				s_q <= SW'(cnt_q);
				if (!pos_rd_q[SW]) status_q <= ST_DUP;
			end
			S_DEC_CHK: begin
				s_q <= pos_rd_q[SW-1:0];
				if (pos_rd_q[SW]) status_q <= ST_IGNORED;
			end
			S_DEC_CMP: if (!(k_q < rk_q)) status_q <= ST_IGNORED;
			S_EXT_RD: begin
				oitem_q <= ri_q;
				okey_q <= rk_q;
				s_q <= '0;
			end
			S_EXT_LAST: begin
				k_q <= rk_q;
				it_q <= ri_q;
			end
			S_UP_CMP: if (k_q < rk_q) s_q <= parent;
			S_DN_CMP: begin
				lk_q <= rk_q;
				li_q <= ri_q;
			end
			S_DN_SWAP: if (pick_k < k_q) s_q <= pick_s;
			default: ;
		endcase
	end

	assign out_valid = ovalid_q;
	assign status = status_q;
	assign out_item = oitem_q;
	assign out_key = KEY_W'(okey_q);
	assign occupancy = OCC_W'(cnt_q);

	`ASSERT_IMP(a_cnt_cap, clk, arst_n, 1'b1, cnt_q <= CW'(CAPACITY))
	`ASSERT_IMP(a_busy_ready, clk, arst_n, state_q != S_IDLE, !in_ready)
	`ASSERT_NEXT(a_done_out, clk, arst_n, state_q == S_DONE || state_q == S_PLACE, out_valid)
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
endmodule

// ===== bench/indexed_min_heap_decrease_key_unit_test.sv =====
// Testbench for the indexed min-heap unit: insert, extract-min and decrease-key traffic.
// Checks every result against an in-bench heap through a small scoreboard class.
// Depends on imh_pkg and indexed_min_heap_decrease_key_unit.
module indexed_min_heap_decrease_key_unit_test;
	import imh_pkg::*;

	localparam int CAP = 256;
	localparam int RANDOM_OPS = 1530;
	localparam int IDLE_LIMIT = 5000;

	typedef struct packed {
		status_t st;
		logic [7:0] item;
		logic [31:0] key;
		logic [8:0] occ;
	} heap_result_t;

	class heap_scoreboard;
		logic [31:0] keys[CAP];
		logic [7:0] items[CAP];
		int slot_of[256];
		bit present[256];
		int count;
		heap_result_t pending[$];
		int errors;

		function void clear();
			count = 0;
			errors = 0;
			foreach (present[i]) begin
				present[i] = 0;
				slot_of[i] = 0;
			end
		endfunction

		function void swap_slots(int a, int b);
			logic [31:0] k;
			logic [7:0] t;
			k = keys[a];
			t = items[a];
			keys[a] = keys[b];
			items[a] = items[b];
			keys[b] = k;
			items[b] = t;
			slot_of[items[a]] = a;
			slot_of[items[b]] = b;
		endfunction

		function void sift_up(int s);
			int up;
			while (s > 0) begin
				up = (s - 1) / 2;
				if (keys[s] < keys[up]) begin
					swap_slots(s, up);
					s = up;
				end else
					break;
			end
		endfunction

		function void sift_down(int s);
			int l, r, best;
			forever begin
				l = 2 * s + 1;
				r = 2 * s + 2;
				best = s;
				if (l < count && keys[l] < keys[best])
					best = l;
				if (r < count && keys[r] < keys[best])
					best = r;
				if (best == s)
					break;
				swap_slots(s, best);
				s = best;
			end
		endfunction

		function void note_op(op_t op, logic [7:0] id, logic [31:0] key);
			heap_result_t r;
			int s;
			r = '{ST_OK, 8'd0, 32'd0, 9'd0};
			case (op)
				OP_INSERT: begin
					if (count >= CAP)
						r.st = ST_FULL;
					else if (present[id])
						r.st = ST_DUP;
					else begin
						keys[count] = key;
						items[count] = id;
						slot_of[id] = count;
						present[id] = 1;
						count++;
						sift_up(count - 1);
					end
				end
				OP_EXTRACT: begin
					if (count == 0) begin
						r.st = ST_EMPTY;
						r.key = '1;
					end else begin
						r.item = items[0];
						r.key = keys[0];
						keys[0] = keys[count - 1];
						items[0] = items[count - 1];
						slot_of[items[0]] = 0;
						count--;
						present[r.item] = 0;
						if (count > 0)
							sift_down(0);
					end
				end
				OP_DECREASE: begin
					s = slot_of[id];
					if (!present[id] || s >= count || keys[s] <= key)
						r.st = ST_IGNORED;
					else begin
						keys[s] = key;
						sift_up(s);
					end
				end
				default: ;
			endcase
			r.occ = 9'(count);
			pending = {pending, r};
		endfunction

		task check(heap_result_t got);
			heap_result_t w;
			if (pending.size() == 0) begin
				report("result with nothing pending", 0, 0);
				return;
			end
			w = pending.pop_front();
			if (got.st != w.st)
				report("status", got.st, w.st);
			if (got.item != w.item)
				report("out_item", got.item, w.item);
			if (got.key != w.key)
				report("out_key", got.key, w.key);
			if (got.occ != w.occ)
				report("occupancy", got.occ, w.occ);
		endtask

		task report(string what, longint got, longint want);
			errors++;
			if (errors <= 50)
				$display("mismatch %s: got %0d want %0d", what, got, want);
		endtask
	endclass

	logic clk, arst_n, in_valid, in_ready, out_valid, out_ready;
	logic [1:0] mode;
	logic [7:0] item_id, out_item;
	logic [31:0] key_value, out_key;
	logic [2:0] status;
	logic [8:0] occupancy;
	heap_scoreboard board;
	bit calm;
	int idle_cycles;

	indexed_min_heap_decrease_key_unit u_dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .item_id(item_id), .key_value(key_value),
		.out_valid(out_valid), .out_ready(out_ready), .status(status),
		.out_item(out_item), .out_key(out_key), .occupancy(occupancy)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		board = new();
		board.clear();
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			board.note_op(op_t'(mode), item_id, key_value);
		if (arst_n && out_valid && out_ready)
			board.check(heap_result_t'{status_t'(status), out_item, out_key, occupancy});
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		int n;
		out_ready = 0;
		@(negedge clk);
		forever begin
			if (!calm && $urandom_range(0, 5) == 0) begin
				out_ready <= 0;
				n = $urandom_range(1, 7);
				repeat (n) @(negedge clk);
			end
			out_ready <= 1;
			@(negedge clk);
		end
	end

	task automatic send(op_t op, logic [7:0] id, logic [31:0] key);
		int n;
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 0;
			n = $urandom_range(1, 7);
			repeat (n) @(negedge clk);
		end
		in_valid <= 1;
		mode <= op;
		item_id <= id;
		key_value <= key;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [31:0] pick_key();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 15);
			1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
			default: return $urandom();
		endcase
	endfunction

	task automatic drain();
		in_valid <= 0;
		while (board.pending.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		op_t op;
		int r;
		arst_n = 0;
		in_valid = 0;
		mode = OP_INSERT;
		item_id = 0;
		key_value = 0;
		repeat (6) @(negedge clk);
		arst_n = 1;

		send(OP_EXTRACT, 8'd0, 32'd0);
		send(OP_DECREASE, 8'd5, 32'd1);
		send(OP_INSERT, 8'd255, 32'hFFFF_FFFF);
		send(OP_INSERT, 8'd0, 32'd0);
		send(OP_INSERT, 8'd0, 32'd7);
		send(OP_INSERT, 8'd17, 32'd100);
		send(OP_INSERT, 8'd18, 32'd100);
		send(OP_DECREASE, 8'd17, 32'd100);
		send(OP_DECREASE, 8'd17, 32'd200);
		send(OP_DECREASE, 8'd255, 32'd50);
		send(OP_DECREASE, 8'd18, 32'd0);
		send(OP_NONE, 8'hAA, 32'h5555_AAAA);
		repeat (6) send(OP_EXTRACT, 8'd0, 32'd0);
		drain();

		// fill to capacity, then hit full; items 0..255 make the whole table present
		for (int i = 0; i < CAP; i++)
			send(OP_INSERT, i[7:0], pick_key());
		send(OP_INSERT, 8'd3, 32'd1);
		for (int i = 0; i < CAP + 2; i++)
			send(OP_EXTRACT, 8'd0, 32'd0);
		drain();

		for (int i = 0; i < RANDOM_OPS - 2 * CAP; i++) begin
			if (i > RANDOM_OPS - 2 * CAP - 150)
				calm = 1;
			r = $urandom_range(0, 99);
			if (board.count < 40 && r < 55 || r < 35)
				op = OP_INSERT;
			else if (r < 70)
				op = OP_EXTRACT;
			else if (r < 97)
				op = OP_DECREASE;
			else
				op = OP_NONE;
			send(op, 8'($urandom_range(0, 255)), pick_key());
		end

		drain();
		repeat (60) @(negedge clk);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		wait (idle_cycles >= IDLE_LIMIT);
		$display("FAILURE");
		$finish;
	end
endmodule
